### hdl/pca_pkg.sv
`timescale 1ns / 1ps

package pca_pkg;

    localparam int PALETTE_SIZE_DEFAULT = 256;

    localparam logic [2:0] KIND_ALLOC  = 3'd0;
    localparam logic [2:0] KIND_LOOKUP = 3'd1;
    localparam logic [2:0] KIND_WRITE  = 3'd2;
    localparam logic [2:0] KIND_CLOSE  = 3'd3;
    localparam logic [2:0] KIND_FIXED  = 3'd4;

    localparam logic [1:0] OUTCOME_EXACT = 2'd0;
    localparam logic [1:0] OUTCOME_ALLOC = 2'd1;
    localparam logic [1:0] OUTCOME_NEAR  = 2'd2;
    localparam logic [1:0] OUTCOME_OTHER = 2'd3;

    localparam logic [7:0] FIX_RED_MASK   = 8'he0;
    localparam logic [7:0] FIX_GREEN_MASK = 8'h1c;
    localparam logic [7:0] FIX_BLUE_MASK  = 8'h03;

    localparam int DIST_W = 18;

    typedef struct packed {
        logic       capture;
        logic       sweep_clear;
        logic       sweep_fixed;
        logic       scan_rd;
        logic       single_rd;
        logic       single_wr;
        logic       alloc_wr;
        logic       set_full;
        logic       emit;
        logic [1:0] outcome;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       sweep_last;
        logic       pipe_busy;
        logic       best_zero;
        logic       has_free;
        logic       out_free;
    } dp_status_t;

    // 3-3-2 palette entry for the low byte of an index, packed r,g,b
    function automatic logic [23:0] fixed_color(input logic [7:0] k);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = k & FIX_RED_MASK;
        g = (k & FIX_GREEN_MASK) << 3;
        b = (k & FIX_BLUE_MASK) << 6;
        return {r, g, b};
    endfunction

endpackage

### hdl/pca_ctrl.sv
`timescale 1ns / 1ps

module pca_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  pca_pkg::dp_status_t status,
    output pca_pkg::dp_cmd_t    cmd
);
    import pca_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_DRAIN  = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_FIXED  = 4'd6;
    localparam logic [3:0] S_READ   = 4'd7;
    localparam logic [3:0] S_RESP   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep_clear = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (status.kind)
                    KIND_ALLOC:
                    begin
                        state_next = S_SCAN;
                    end
                    KIND_FIXED:
                    begin
                        cmd.set_full = 1'b1;
                        state_next   = S_FIXED;
                    end
                    KIND_WRITE:
                    begin
                        cmd.single_wr = 1'b1;
                        state_next    = S_READ;
                    end
                    KIND_CLOSE:
                    begin
                        cmd.set_full = 1'b1;
                        state_next   = S_READ;
                    end
                    default:
                    begin
                        state_next = S_READ;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                    priority if (status.best_zero)
                    begin
                        cmd.outcome = OUTCOME_EXACT;
                    end
                    else if (status.has_free)
                    begin
                        cmd.outcome  = OUTCOME_ALLOC;
                        cmd.alloc_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.outcome = OUTCOME_NEAR;
                    end
                end
            end
            S_FIXED:
            begin
                cmd.sweep_fixed = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.single_rd = 1'b1;
                state_next    = S_RESP;
            end
            S_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.outcome = OUTCOME_OTHER;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // the best entry must be final before the allocate decision
    a_decide_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |-> !status.pipe_busy)
        else $error("decision taken while scan pipeline busy");

    a_scan_follows_decode: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && ($past(state_reg) != S_SCAN))
            |-> ($past(state_reg) == S_DECODE) && ($past(status.kind) == KIND_ALLOC))
        else $error("scan started without an allocate transaction");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result issued while output register full");

endmodule

### hdl/pca_datapath.sv
`timescale 1ns / 1ps

module pca_datapath #(
    parameter int PALETTE_SIZE = pca_pkg::PALETTE_SIZE_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pca_pkg::dp_cmd_t    cmd,
    output pca_pkg::dp_status_t status,
    input  logic [2:0]          kind,
    input  logic [7:0]          entry_index,
    input  logic [7:0]          red_in,
    input  logic [7:0]          green_in,
    input  logic [7:0]          blue_in,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [7:0]          result_index,
    output logic [7:0]          red_out,
    output logic [7:0]          green_out,
    output logic [7:0]          blue_out,
    output logic [1:0]          outcome
);
    import pca_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_SIZE);
    localparam int CNT_W = IDX_W + 1;
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    logic [23:0] mem [PALETTE_SIZE];

    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic [CNT_W-1:0] next_free_reg;
    logic [CNT_W-1:0] next_free_next;
    logic             v1_reg;
    logic             v2_reg;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    logic [2:0]       kind_reg;
    logic [7:0]       index_reg;
    logic [23:0]      color_reg;
    logic [23:0]      rd_data_reg;
    logic [IDX_W-1:0] idx1_reg;
    logic [IDX_W-1:0] idx2_reg;
    logic [23:0]      color2_reg;
    logic [15:0]      sq_r_reg;
    logic [15:0]      sq_g_reg;
    logic [15:0]      sq_b_reg;
    logic [DIST_W-1:0] best_d_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [23:0]      best_color_reg;
    logic [7:0]       result_index_reg;
    logic [23:0]      color_out_reg;
    logic [1:0]       outcome_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [23:0]      mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic             in_range;
    logic             sweep_last;
    logic             stepping;
    logic             out_free;
    logic [DIST_W-1:0] dist_sum;
    logic [15:0]      sq_r;
    logic [15:0]      sq_g;
    logic [15:0]      sq_b;
    logic [7:0]       emit_index;
    logic [23:0]      emit_color;

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 16'(d) * 16'(d);
    endfunction

    assign in_range   = CMP_W'(index_reg) < CMP_W'(PALETTE_SIZE);
    assign sweep_last = cnt_reg == IDX_W'(PALETTE_SIZE - 1);
    assign stepping   = cmd.sweep_clear | cmd.sweep_fixed | cmd.scan_rd;
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    assign status.kind       = kind_reg;
    assign status.sweep_last = sweep_last;
    assign status.pipe_busy  = v1_reg | v2_reg;
    assign status.best_zero  = best_d_reg == '0;
    assign status.has_free   = next_free_reg < CNT_W'(PALETTE_SIZE);
    assign status.out_free   = out_free;

    // single write port: clear sweep, fixed sweep, write transaction, allocation
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = '0;
        priority if (cmd.sweep_clear)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.sweep_fixed)
        begin
            mem_we    = 1'b1;
            mem_wdata = fixed_color(8'(cnt_reg));
        end
        else if (cmd.single_wr)
        begin
            mem_we    = in_range;
            mem_waddr = IDX_W'(index_reg);
            mem_wdata = color_reg;
        end
        else if (cmd.alloc_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = next_free_reg[IDX_W-1:0];
            mem_wdata = color_reg;
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    assign mem_re    = cmd.scan_rd | cmd.single_rd;
    assign mem_raddr = cmd.scan_rd ? cnt_reg : IDX_W'(index_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.capture)
        begin
            cnt_next = '0;
        end
        else if (stepping)
        begin
            cnt_next = sweep_last ? '0 : cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        next_free_next = next_free_reg;
        if (cmd.set_full)
        begin
            next_free_next = CNT_W'(PALETTE_SIZE);
        end
        else if (cmd.alloc_wr)
        begin
            next_free_next = next_free_reg + 1'b1;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            next_free_reg <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            next_free_reg <= next_free_next;
            v1_reg        <= cmd.scan_rd;
            v2_reg        <= v1_reg;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // scan pipeline: read, squares, sum and compare
    assign sq_r = sq_diff(color_reg[23:16], rd_data_reg[23:16]);
    assign sq_g = sq_diff(color_reg[15:8], rd_data_reg[15:8]);
    assign sq_b = sq_diff(color_reg[7:0], rd_data_reg[7:0]);
    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

    always_comb
    begin
        unique case (cmd.outcome)
            OUTCOME_EXACT, OUTCOME_NEAR:
            begin
                emit_index = 8'(best_idx_reg);
                emit_color = best_color_reg;
            end
            OUTCOME_ALLOC:
            begin
                emit_index = 8'(next_free_reg);
                emit_color = color_reg;
            end
            default:
            begin
                emit_index = index_reg;
                emit_color = in_range ? rd_data_reg : '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= kind;
            index_reg <= entry_index;
            color_reg <= {red_in, green_in, blue_in};
        end
        if (cmd.scan_rd)
        begin
            idx1_reg <= cnt_reg;
        end
        if (v1_reg)
        begin
            idx2_reg   <= idx1_reg;
            color2_reg <= rd_data_reg;
            sq_r_reg   <= sq_r;
            sq_g_reg   <= sq_g;
            sq_b_reg   <= sq_b;
        end
        // strict compare keeps the lowest index on a tie
        if (cmd.capture)
        begin
            best_d_reg <= '1;
        end
        else if (v2_reg && (dist_sum < best_d_reg))
        begin
            best_d_reg     <= dist_sum;
            best_idx_reg   <= idx2_reg;
            best_color_reg <= color2_reg;
        end
        if (cmd.emit)
        begin
            result_index_reg <= emit_index;
            color_out_reg    <= emit_color;
            outcome_reg      <= cmd.outcome;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign result_index = result_index_reg;
    assign red_out      = color_out_reg[23:16];
    assign green_out    = color_out_reg[15:8];
    assign blue_out     = color_out_reg[7:0];
    assign outcome      = outcome_reg;

    a_next_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= CNT_W'(PALETTE_SIZE))
        else $error("next free slot beyond palette");

    a_alloc_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_wr |-> status.has_free && !status.best_zero)
        else $error("allocation without free slot or with exact match");

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> $past(v1_reg))
        else $error("scan pipeline stage without source");

endmodule

### hdl/palette_color_allocator.sv
`timescale 1ns / 1ps

// Palette color allocator. After reset the palette memory is cleared one entry per
// cycle, and the block stalls requests until the clear is done. An allocate transaction
// scans the whole palette through the single memory read port, one entry per cycle;
// a fixed palette load writes one entry per cycle. Lookup, write entry, close and the
// unused kinds pass through the decode, read and response states. One transaction is
// worked on at a time; a finished result waits in the output register while the next
// request is accepted.
module palette_color_allocator #(
    parameter int PALETTE_SIZE = pca_pkg::PALETTE_SIZE_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [2:0] kind,
    input  logic [7:0] entry_index,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [7:0] result_index,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out,
    output logic [1:0] outcome
);
    import pca_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    pca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    pca_datapath #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .entry_index  (entry_index),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .result_index (result_index),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .outcome      (outcome)
    );

endmodule
